// File: hw/rtl/poc_pkg.sv
// shared types and constants for the permutation ordinal codec
package poc_pkg;

   localparam int DEFAULT_MAX_ELEMENTS = 256;
   localparam int VALUE_W = 8;
   localparam int SET_LENGTH_W = 9;
   localparam logic [SET_LENGTH_W-1:0] RESET_SET_LENGTH = 9'd256;

   localparam logic MODE_DECODE = 1'b0;
   localparam logic MODE_ENCODE = 1'b1;

   typedef struct packed {
      logic mode;
      logic first;
      logic [VALUE_W-1:0] item_value;
   } poc_req_type;

   typedef struct packed {
      logic [VALUE_W-1:0] result_value;
      logic last;
      logic clamped;
      logic not_found;
   } poc_rsp_type;

   // broadcast control from the top level to every cell
   typedef struct packed {
      logic restart;
      logic load;
      logic remove;
      logic mode;
   } poc_ctl_type;

endpackage

// File: hw/rtl/permutation_ordinal_codec.sv
// top level of the permutation to ordinal code converter
//
// usage:
//   req channel carries one element per transfer: mode, first and item_value
//   an item with first set restarts the remaining list as 0..n-1, latches
//   the mode and takes n from the csr register (0 acts as 1, capped at
//   MAX_ELEMENTS); csr writes belong between sets, with nothing in flight
//   decode (mode 0): item_value is an index into the remaining list, the
//   entry is returned and removed; an index past the end is clamped
//   encode (mode 1): item_value is an element, its position is returned and
//   the entry removed; an absent element returns 0 with not_found
//   rsp channel gives exactly one result per request, in order
// timing:
//   rsp_valid rises in the cycle after the request transfer; one item
//   per cycle is sustained while rsp_stall does not hold a waiting result,
//   since every cell of the list chain compares and shifts in parallel
//   while rsp_stall holds a waiting result, req_stall rises and the result
//   register holds; when it drains a new request is taken in the same cycle
// reset:
//   synchronous; the list returns to 0..n-1, n = min(256, MAX_ELEMENTS),
//   the set position to 0, mode to decode and the output goes empty
module permutation_ordinal_codec
   import poc_pkg::*;
#(
   parameter int MAX_ELEMENTS = DEFAULT_MAX_ELEMENTS
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  poc_req_type req_data,
   output logic rsp_valid,
   input  logic rsp_stall,
   output poc_rsp_type rsp_data,
   input  logic csr_write,
   input  logic [SET_LENGTH_W-1:0] csr_data
);

   localparam int ELEM_W = $clog2(MAX_ELEMENTS);
   localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
   localparam int WIDE_W = (CNT_W > SET_LENGTH_W) ? CNT_W : SET_LENGTH_W;
   localparam int PAD_W = (ELEM_W > VALUE_W) ? ELEM_W : VALUE_W;
   localparam logic [WIDE_W-1:0] MAX_WIDE = WIDE_W'(MAX_ELEMENTS);

   // configuration and set state
   logic [SET_LENGTH_W-1:0] set_length_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] size_ff, size_in;
   logic [CNT_W-1:0] position_ff, position_in;
   logic mode_ff, mode_in;

   // result register
   logic rsp_valid_ff, rsp_valid_in;
   poc_rsp_type rsp_data_ff, rsp_data_in;

   logic accept;
   logic [WIDE_W-1:0] len_wide;
   logic [CNT_W-1:0] len_eff;
   logic [CNT_W-1:0] count_eff;
   logic [CNT_W-1:0] position_eff;
   logic active;
   logic index_over;
   logic [ELEM_W-1:0] idx;
   logic hit;
   logic [ELEM_W-1:0] picked;
   logic [ELEM_W-1:0] found_pos;
   logic [PAD_W-1:0] picked_pad;
   logic [PAD_W-1:0] found_pad;
   poc_ctl_type ctl;

   // output register parts the two sides: stall only when full and blocked
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept = req_valid && !req_stall;

   // effective set length, clamped into 1..MAX_ELEMENTS
   always_comb begin
      len_wide = WIDE_W'(set_length_ff);
      if (len_wide == '0) begin
         len_eff = CNT_W'(1);
      end else if (len_wide > MAX_WIDE) begin
         len_eff = CNT_W'(MAX_ELEMENTS);
      end else begin
         len_eff = CNT_W'(len_wide);
      end
   end

   // state as seen by this transfer, after a restart on first
   assign mode_in = req_data.first ? req_data.mode : mode_ff;
   assign size_in = req_data.first ? len_eff : size_ff;
   assign count_eff = req_data.first ? len_eff : count_ff;
   assign position_eff = req_data.first ? '0 : position_ff;
   assign active = (position_eff < size_in) && (count_eff != '0);

   // decode index, clamped to the last remaining entry
   assign index_over = WIDE_W'(req_data.item_value) >= WIDE_W'(count_eff);
   assign idx = index_over ? ELEM_W'(count_eff - CNT_W'(1))
                           : ELEM_W'(WIDE_W'(req_data.item_value));

   always_comb begin
      ctl.restart = req_valid && req_data.first;
      ctl.load = accept;
      ctl.remove = accept && active;
      ctl.mode = mode_in;
   end

   poc_chain #(
      .MAX_ELEMENTS(MAX_ELEMENTS)
   ) u_chain (
      .clock(clock),
      .reset(reset),
      .ctl(ctl),
      .item(req_data.item_value),
      .idx(idx),
      .count(count_eff),
      .hit(hit),
      .picked(picked),
      .found_pos(found_pos)
   );

   assign picked_pad = PAD_W'(picked);
   assign found_pad = PAD_W'(found_pos);

   // result and next set state
   always_comb begin
      rsp_data_in = '0;
      count_in = count_eff;
      position_in = position_eff;
      if (!active) begin
         // item after the set is complete: flag only, state untouched
         if (mode_in == MODE_ENCODE) begin
            rsp_data_in.not_found = 1'b1;
         end else begin
            rsp_data_in.clamped = 1'b1;
         end
      end else begin
         position_in = position_eff + CNT_W'(1);
         rsp_data_in.last = (position_in == size_in);
         if (mode_in == MODE_DECODE) begin
            rsp_data_in.result_value = picked_pad[VALUE_W-1:0];
            rsp_data_in.clamped = index_over;
            count_in = count_eff - CNT_W'(1);
         end else if (hit) begin
            rsp_data_in.result_value = found_pad[VALUE_W-1:0];
            count_in = count_eff - CNT_W'(1);
         end else begin
            rsp_data_in.not_found = 1'b1;
         end
      end
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         set_length_ff <= RESET_SET_LENGTH;
         mode_ff <= MODE_DECODE;
         position_ff <= '0;
         size_ff <= (MAX_ELEMENTS < 256) ? CNT_W'(MAX_ELEMENTS) : CNT_W'(256);
         count_ff <= (MAX_ELEMENTS < 256) ? CNT_W'(MAX_ELEMENTS) : CNT_W'(256);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            set_length_ff <= csr_data;
         end
         if (accept) begin
            mode_ff <= mode_in;
            size_ff <= size_in;
            count_ff <= count_in;
            position_ff <= position_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload register, loads only on a request transfer
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

// File: hw/rtl/poc_cell.sv
// one cell of the remaining-list chain: holds one entry and shifts it down on removal
module poc_cell
   import poc_pkg::*;
#(
   parameter int MAX_ELEMENTS = DEFAULT_MAX_ELEMENTS,
   parameter int INDEX = 0
) (
   input  logic clock,
   input  logic reset,
   input  poc_ctl_type ctl,
   input  logic [VALUE_W-1:0] item,
   input  logic [$clog2(MAX_ELEMENTS)-1:0] idx,
   input  logic [$clog2(MAX_ELEMENTS+1)-1:0] count,
   input  logic hit,
   input  logic [$clog2(MAX_ELEMENTS)-1:0] upper_value,
   output logic [$clog2(MAX_ELEMENTS)-1:0] value,
   output logic match,
   output logic [$clog2(MAX_ELEMENTS)-1:0] pick,
   output logic [$clog2(MAX_ELEMENTS)-1:0] pos
);

   localparam int ELEM_W = $clog2(MAX_ELEMENTS);
   localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
   localparam int CMP_W = (ELEM_W > VALUE_W) ? ELEM_W : VALUE_W;
   localparam logic [ELEM_W-1:0] MY_INDEX = ELEM_W'(INDEX);

   logic [ELEM_W-1:0] value_ff;
   logic [ELEM_W-1:0] value_in;
   logic [CMP_W-1:0] value_cmp;
   logic [CMP_W-1:0] item_cmp;
   logic in_list;
   logic shift;

   // a restart in the same transfer sees the fresh list
   assign value = ctl.restart ? MY_INDEX : value_ff;
   assign value_cmp = CMP_W'(value);
   assign item_cmp = CMP_W'(item);
   assign in_list = CNT_W'(INDEX) < count;
   assign match = in_list && (value_cmp == item_cmp);

   assign pick = (MY_INDEX == idx) ? value : '0;
   assign pos = match ? MY_INDEX : '0;

   // list stays sorted, so removal in encode moves every entry at or above the value
   always_comb begin
      if (ctl.mode == MODE_DECODE) begin
         shift = MY_INDEX >= idx;
      end else begin
         shift = hit && (value_cmp >= item_cmp);
      end
      value_in = (ctl.remove && shift) ? upper_value : value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= MY_INDEX;
      end else if (ctl.load) begin
         value_ff <= value_in;
      end
   end

endmodule

// File: hw/rtl/poc_chain.sv
// row of list cells with the pick and position reductions
module poc_chain
   import poc_pkg::*;
#(
   parameter int MAX_ELEMENTS = DEFAULT_MAX_ELEMENTS
) (
   input  logic clock,
   input  logic reset,
   input  poc_ctl_type ctl,
   input  logic [VALUE_W-1:0] item,
   input  logic [$clog2(MAX_ELEMENTS)-1:0] idx,
   input  logic [$clog2(MAX_ELEMENTS+1)-1:0] count,
   output logic hit,
   output logic [$clog2(MAX_ELEMENTS)-1:0] picked,
   output logic [$clog2(MAX_ELEMENTS)-1:0] found_pos
);

   localparam int ELEM_W = $clog2(MAX_ELEMENTS);

   logic [ELEM_W-1:0] value_all [MAX_ELEMENTS];
   logic [ELEM_W-1:0] pick_all [MAX_ELEMENTS];
   logic [ELEM_W-1:0] pos_all [MAX_ELEMENTS];
   logic [MAX_ELEMENTS-1:0] match_all;

   for (genvar k = 0; k < MAX_ELEMENTS; k++) begin : g_cell
      logic [ELEM_W-1:0] upper;
      if (k == MAX_ELEMENTS - 1) begin : g_top
         assign upper = value_all[k];
      end else begin : g_mid
         assign upper = value_all[k+1];
      end
      poc_cell #(
         .MAX_ELEMENTS(MAX_ELEMENTS),
         .INDEX(k)
      ) u_cell (
         .clock(clock),
         .reset(reset),
         .ctl(ctl),
         .item(item),
         .idx(idx),
         .count(count),
         .hit(hit),
         .upper_value(upper),
         .value(value_all[k]),
         .match(match_all[k]),
         .pick(pick_all[k]),
         .pos(pos_all[k])
      );
   end

   assign hit = |match_all;

   // at most one cell selects and at most one cell matches, so an or-tree is the mux
   always_comb begin
      picked = '0;
      found_pos = '0;
      for (int k = 0; k < MAX_ELEMENTS; k++) begin
         picked = picked | pick_all[k];
         found_pos = found_pos | pos_all[k];
      end
   end

endmodule
